/* rtl/r2h_pkg.sv */
// ----------------------------------------------------------------------------
// r2h_pkg
// Shared types, widths and divider step functions for the RGB to HSV converter.
// ----------------------------------------------------------------------------
package r2h_pkg;

    localparam int CH_W           = 8;
    localparam int HUE_DIV_W      = 11;
    localparam int SAT_DIV_W      = 8;
    localparam int FRAC_W         = 16;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = FRAC_W / BITS_PER_STAGE;
    localparam int IN_TDATA_W     = 24;
    localparam int OUT_TDATA_W    = 40;

    typedef enum logic [2:0] {
        SEC_RED   = 3'b001,
        SEC_GREEN = 3'b010,
        SEC_BLUE  = 3'b100
    } t_sector;

    typedef struct packed {
        logic [HUE_DIV_W-1:0] hue_rem;
        logic [HUE_DIV_W-1:0] hue_div;
        logic [FRAC_W-1:0]    hue_quo;
        logic [SAT_DIV_W-1:0] sat_rem;
        logic [SAT_DIV_W-1:0] sat_div;
        logic [FRAC_W-1:0]    sat_quo;
        logic [CH_W-1:0]      brightness;
    } t_div_data;

    // One restoring step of the fractional hue division: {quotient bit, remainder}.
    function automatic logic [HUE_DIV_W:0] hue_step(input logic [HUE_DIV_W-1:0] rem,
                                                    input logic [HUE_DIV_W-1:0] div);
        logic [HUE_DIV_W:0] t;
        logic [HUE_DIV_W:0] s;
        t = {rem, 1'b0};
        s = t - {1'b0, div};
        if (t >= {1'b0, div}) begin
            hue_step = {1'b1, s[HUE_DIV_W-1:0]};
        end else begin
            hue_step = {1'b0, rem[HUE_DIV_W-2:0], 1'b0};
        end
    endfunction

    // One restoring step of the saturation division. A remainder equal to the
    // divisor stays there and gives a one in every step.
    function automatic logic [SAT_DIV_W:0] sat_step(input logic [SAT_DIV_W-1:0] rem,
                                                    input logic [SAT_DIV_W-1:0] div);
        logic [SAT_DIV_W:0] t;
        logic [SAT_DIV_W:0] s;
        t = {rem, 1'b0};
        s = t - {1'b0, div};
        if (t >= {1'b0, div}) begin
            sat_step = {1'b1, s[SAT_DIV_W-1:0]};
        end else begin
            sat_step = {1'b0, t[SAT_DIV_W-1:0]};
        end
    endfunction

endpackage

/* rtl/r2h_front.sv */
// ----------------------------------------------------------------------------
// r2h_front
// Two pipeline stages: channel ordering, then spread, hue numerator and divisors.
// ----------------------------------------------------------------------------
module r2h_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [r2h_pkg::CH_W-1:0]     i_red,
    input  logic [r2h_pkg::CH_W-1:0]     i_green,
    input  logic [r2h_pkg::CH_W-1:0]     i_blue,
    output logic                         o_valid,
    input  logic                         i_ready,
    output r2h_pkg::t_div_data           o_data
);
    import r2h_pkg::*;

    // Stage A registers
    logic            r_a_valid;
    logic [CH_W-1:0] r_a_red, r_a_green, r_a_blue, r_a_max, r_a_min;
    t_sector         r_a_sector;
    logic [CH_W-1:0] n_a_max, n_a_min;
    t_sector         n_a_sector;
    logic            a_ready;

    // Stage B registers
    logic            r_b_valid;
    t_div_data       r_b_data;
    t_div_data       n_b_data;
    logic            b_ready;

    logic [CH_W-1:0]      spread;
    logic [HUE_DIV_W-1:0] den;
    logic [HUE_DIV_W:0]   num_raw;
    logic [HUE_DIV_W:0]   num_wrap;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

    // The first largest channel in red, green, blue order picks the sector.
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_a_sector = SEC_RED;
            n_a_max    = i_red;
        end else if (i_green >= i_blue) begin
            n_a_sector = SEC_GREEN;
            n_a_max    = i_green;
        end else begin
            n_a_sector = SEC_BLUE;
            n_a_max    = i_blue;
        end
        if (i_red <= i_green && i_red <= i_blue) begin
            n_a_min = i_red;
        end else if (i_green <= i_blue) begin
            n_a_min = i_green;
        end else begin
            n_a_min = i_blue;
        end
    end

    always_comb begin
        spread = r_a_max - r_a_min;
        den    = {1'b0, spread, 2'b00} + {2'b00, spread, 1'b0};
        case (r_a_sector)
            SEC_RED: begin
                num_raw = {4'b0, r_a_green} - {4'b0, r_a_blue};
            end
            SEC_GREEN: begin
                num_raw = {3'b0, spread, 1'b0} + {4'b0, r_a_blue} - {4'b0, r_a_red};
            end
            SEC_BLUE: begin
                num_raw = {2'b0, spread, 2'b0} + {4'b0, r_a_red} - {4'b0, r_a_green};
            end
            default: begin
                num_raw = '0;
            end
        endcase
        // A negative numerator wraps by a full turn.
        num_wrap = num_raw[HUE_DIV_W] ? (num_raw + {1'b0, den}) : num_raw;

        n_b_data            = '0;
        n_b_data.brightness = r_a_max;
        if (spread == '0) begin
            // Grey pixel: zero numerators over a unit divisor give zero quotients.
            n_b_data.hue_div = HUE_DIV_W'(1);
            n_b_data.sat_div = SAT_DIV_W'(1);
        end else begin
            n_b_data.hue_rem = num_wrap[HUE_DIV_W-1:0];
            n_b_data.hue_div = den;
            n_b_data.sat_rem = spread;
            n_b_data.sat_div = r_a_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_red    <= i_red;
            r_a_green  <= i_green;
            r_a_blue   <= i_blue;
            r_a_max    <= n_a_max;
            r_a_min    <= n_a_min;
            r_a_sector <= n_a_sector;
        end
        if (b_ready && r_a_valid) begin
            r_b_data <= n_b_data;
        end
    end

endmodule

/* rtl/r2h_div_stage.sv */
// ----------------------------------------------------------------------------
// r2h_div_stage
// One divider pipeline stage: two quotient bits for both hue and saturation.
// ----------------------------------------------------------------------------
module r2h_div_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  r2h_pkg::t_div_data i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output r2h_pkg::t_div_data o_data
);
    import r2h_pkg::*;

    logic       r_valid;
    t_div_data  r_data;
    t_div_data  n_data;
    logic [HUE_DIV_W:0] hue_s1, hue_s2;
    logic [SAT_DIV_W:0] sat_s1, sat_s2;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        hue_s1 = hue_step(i_data.hue_rem, i_data.hue_div);
        hue_s2 = hue_step(hue_s1[HUE_DIV_W-1:0], i_data.hue_div);
        sat_s1 = sat_step(i_data.sat_rem, i_data.sat_div);
        sat_s2 = sat_step(sat_s1[SAT_DIV_W-1:0], i_data.sat_div);

        n_data         = i_data;
        n_data.hue_rem = hue_s2[HUE_DIV_W-1:0];
        n_data.hue_quo = {i_data.hue_quo[FRAC_W-3:0], hue_s1[HUE_DIV_W], hue_s2[HUE_DIV_W]};
        n_data.sat_rem = sat_s2[SAT_DIV_W-1:0];
        n_data.sat_quo = {i_data.sat_quo[FRAC_W-3:0], sat_s1[SAT_DIV_W], sat_s2[SAT_DIV_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

/* rtl/rgb_to_hsv_converter.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pipelined RGB to HSV pixel converter with stream handshakes on both sides.
// ----------------------------------------------------------------------------
// Pixels arrive on the slave stream: s_axis_tdata carries red, green and blue
// bytes, red in the lowest bits. Each accepted transfer yields exactly one
// result transfer on the master stream, carrying hue and saturation as 16-bit
// fractions of one (truncated) and the value (largest channel) as a byte.
// An accepted input transfer passes through two front stages, which order the
// channels and form the hue numerator and the divisors, then eight divider
// stages that produce two quotient bits each for both divisions in parallel.
// Throughput is one pixel per cycle while the receiver does not stall, set by
// the fully pipelined divider.
// Every stage holds its own valid bit and takes new data whenever it is empty
// or its successor moves, so bubbles close up. When the receiver stalls, the
// stages fill and s_axis_tready falls only once every stage holds a pixel;
// nothing is dropped or repeated. Synchronous active-low reset empties the
// pipeline; data registers are not cleared.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
    input  logic [r2h_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // Fields from bit 0: hue[15:0], saturation[31:16], brightness[39:32].
    output logic [r2h_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import r2h_pkg::*;

    // Handshake chain between the front end and the divider stages; index 0
    // is the front end's output, the last index is the master stream.
    logic [DIV_STAGES:0] stage_valid;
    logic [DIV_STAGES:0] stage_ready;
    t_div_data           stage_data [DIV_STAGES+1];

    r2h_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_red   (s_axis_tdata[7:0]),
        .i_green (s_axis_tdata[15:8]),
        .i_blue  (s_axis_tdata[23:16]),
        .o_valid (stage_valid[0]),
        .i_ready (stage_ready[0]),
        .o_data  (stage_data[0])
    );

    for (genvar gi = 0; gi < DIV_STAGES; gi++) begin : g_div
        r2h_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (stage_valid[gi]),
            .o_ready (stage_ready[gi]),
            .i_data  (stage_data[gi]),
            .o_valid (stage_valid[gi+1]),
            .i_ready (stage_ready[gi+1]),
            .o_data  (stage_data[gi+1])
        );
    end

    // The last divider stage's register is the output register.
    assign stage_ready[DIV_STAGES] = m_axis_tready;
    assign m_axis_tvalid = stage_valid[DIV_STAGES];
    assign m_axis_tdata  = {stage_data[DIV_STAGES].brightness,
                            stage_data[DIV_STAGES].sat_quo,
                            stage_data[DIV_STAGES].hue_quo};

    // Input back-pressure only arises from a stalled, occupied output.
    a_tready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while output is free");

    // A black pixel is grey: hue and saturation must both be zero.
    a_black_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[39:32] == 8'd0) |->
        (m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[31:16] == 16'd0))
        else $error("black pixel with non-zero hue or saturation");

    // Non-zero saturation is at least 1/255; zero saturation means grey, so zero hue.
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[31:16] == 16'd0 && m_axis_tdata[15:0] == 16'd0) ||
                           m_axis_tdata[31:16] >= 16'd257))
        else $error("saturation out of range or grey pixel with hue");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Streams pixels through the converter with random gaps on both sides and a
// long output stall. Every result is checked against hue, saturation and
// value worked out here in exact integer arithmetic.
// ----------------------------------------------------------------------------
module testbench;

    import r2h_pkg::*;

    localparam time CLK_HALF      = 6ns;
    localparam int  RANDOM_PIXELS = 950;
    localparam int  IDLE_PERCENT  = 34;
    // The sender offers without gaps over this range of pixels, which covers
    // the long output stall below, so that the pipeline fills and pushes back.
    localparam int  SEND_CALM_LO  = 620;
    localparam int  SEND_CALM_HI  = 820;
    // The receiver takes every result without gaps over this range.
    localparam int  RECV_CALM_LO  = 200;
    localparam int  RECV_CALM_HI  = 400;
    // After this many results the receiver holds off for a long stretch.
    localparam int  STALL_AT      = 650;
    localparam int  STALL_CYCLES  = 60;
    // The drain wait allows ample margin over the pipeline latency.
    localparam int  DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_pixel;

    typedef struct {
        logic [FRAC_W-1:0] hue;
        logic [FRAC_W-1:0] saturation;
        logic [CH_W-1:0]   brightness;
    } t_hsv;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // Fields from bit 0: hue[15:0], saturation[31:16], brightness[39:32].
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Pixels still to be offered, and the colours expected back, oldest first.
    t_pixel pixels_to_send[$];
    t_hsv   expected_colours[$];

    int pixels_sent     = 0;
    int colours_checked = 0;
    int mismatch_count  = 0;
    int stall_left      = 0;
    bit stall_done      = 1'b0;

    rgb_to_hsv_converter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Exact integer conversion. The hue numerator is the sector offset in
    // units of the spread plus the difference of the two other channels,
    // wrapped into one full turn of six spreads before the division.
    function automatic t_hsv predict_hsv(input t_pixel px);
        int     top_ch;
        int     low_ch;
        int     spread;
        int     numer;
        longint scaled;
        t_sector sector;
        t_hsv   res;
        top_ch = px.red;
        low_ch = px.red;
        if (px.green > top_ch) top_ch = px.green;
        if (px.blue  > top_ch) top_ch = px.blue;
        if (px.green < low_ch) low_ch = px.green;
        if (px.blue  < low_ch) low_ch = px.blue;
        spread = top_ch - low_ch;
        res.brightness = top_ch[CH_W-1:0];
        res.hue        = '0;
        res.saturation = '0;
        if (spread != 0) begin
            // Ties for the largest channel go to the first in red, green, blue order.
            if (px.red == top_ch) begin
                sector = SEC_RED;
            end else if (px.green == top_ch) begin
                sector = SEC_GREEN;
            end else begin
                sector = SEC_BLUE;
            end
            case (sector)
                SEC_RED: begin
                    numer = int'(px.green) - int'(px.blue);
                end
                SEC_GREEN: begin
                    numer = 2 * spread + int'(px.blue) - int'(px.red);
                end
                default: begin
                    numer = 4 * spread + int'(px.red) - int'(px.green);
                end
            endcase
            if (numer < 0) numer = numer + 6 * spread;
            scaled  = (longint'(numer) * 65536) / (6 * spread);
            res.hue = scaled[FRAC_W-1:0];
            // A spread equal to the maximum gives exactly one, held at full scale.
            scaled = (longint'(spread) * 65536) / top_ch;
            if (scaled > 65535) scaled = 65535;
            res.saturation = scaled[FRAC_W-1:0];
        end
        return res;
    endfunction

    function automatic t_pixel make_pixel(input int r, input int g, input int b);
        t_pixel px;
        px.red   = r[CH_W-1:0];
        px.green = g[CH_W-1:0];
        px.blue  = b[CH_W-1:0];
        return px;
    endfunction

    // Random pixel, weighted towards grey pixels, ties for the largest channel
    // and channels at the ends of the range.
    function automatic t_pixel random_pixel();
        int     pick;
        int     a;
        int     b;
        t_pixel px;
        pick = $urandom_range(0, 99);
        a    = $urandom_range(0, 255);
        b    = $urandom_range(0, 255);
        px   = IN_TDATA_W'($urandom);
        if (pick < 12) begin
            px = make_pixel(a, a, a);
        end else if (pick < 20) begin
            px = make_pixel(a, a, b);
        end else if (pick < 26) begin
            px = make_pixel(b, a, a);
        end else if (pick < 32) begin
            px = make_pixel(a, b, a);
        end else if (pick < 40) begin
            // One channel pinned at zero or at full scale.
            case ($urandom_range(0, 2))
                0: px.red   = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                1: px.green = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                default: px.blue = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            endcase
        end else if (pick < 46) begin
            // Channels at most two steps apart, for a spread of zero to two unless a channel wraps to zero.
            px = make_pixel(a, (a + $urandom_range(0, 1)) % 256,
                            (a + $urandom_range(0, 2)) % 256);
        end
        return px;
    endfunction

    // Stimulus and end of run.
    initial begin
        pixels_to_send.push_back(make_pixel(  0,   0,   0));
        pixels_to_send.push_back(make_pixel(255, 255, 255));
        pixels_to_send.push_back(make_pixel(128, 128, 128));
        pixels_to_send.push_back(make_pixel(255,   0,   0));
        pixels_to_send.push_back(make_pixel(  0, 255,   0));
        pixels_to_send.push_back(make_pixel(  0,   0, 255));
        // Ties for the largest channel.
        pixels_to_send.push_back(make_pixel(255, 255,   0));
        pixels_to_send.push_back(make_pixel(  0, 255, 255));
        pixels_to_send.push_back(make_pixel(255,   0, 255));
        pixels_to_send.push_back(make_pixel(200, 200, 199));
        // Red largest with blue above green, so the hue wraps past zero.
        pixels_to_send.push_back(make_pixel(200,  10,  50));
        pixels_to_send.push_back(make_pixel(255,   0,   1));
        // Smallest possible spreads, then wider spreads.
        pixels_to_send.push_back(make_pixel(  1,   0,   0));
        pixels_to_send.push_back(make_pixel(255, 254, 254));
        pixels_to_send.push_back(make_pixel(  1,   2,   3));
        pixels_to_send.push_back(make_pixel( 10,  30,  20));
        pixels_to_send.push_back(make_pixel( 85, 170, 255));
        pixels_to_send.push_back(make_pixel(254,   1,   0));
        // Smallest channel zero: full saturation.
        pixels_to_send.push_back(make_pixel(100,   0,  50));
        // Alternating bit and nibble patterns across the channels.
        pixels_to_send.push_back(make_pixel(8'hAA, 8'h55, 8'h0F));
        pixels_to_send.push_back(make_pixel(8'h55, 8'hAA, 8'hF0));
        pixels_to_send.push_back(make_pixel(8'h0F, 8'hF0, 8'hAA));
        for (int i = 0; i < RANDOM_PIXELS; i++) begin
            pixels_to_send.push_back(random_pixel());
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pixels_to_send.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_colours.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

    // Driver. A pixel stays on the bus until its transfer completes; the
    // expected colour is queued as soon as the pixel is offered, which keeps
    // it well ahead of the matching result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pixels_to_send.size() != 0 &&
                ((pixels_sent >= SEND_CALM_LO && pixels_sent < SEND_CALM_HI) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                t_pixel px;
                px = pixels_to_send.pop_front();
                expected_colours.push_back(predict_hsv(px));
                pixels_sent   = pixels_sent + 1;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= px;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor. Checks each result transfer against the oldest expected colour
    // and chooses tready for the next cycle, including the one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                t_hsv got;
                t_hsv want;
                got.hue        = m_axis_tdata[15:0];
                got.saturation = m_axis_tdata[31:16];
                got.brightness = m_axis_tdata[39:32];
                if (expected_colours.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = expected_colours.pop_front();
                    if (got.hue !== want.hue) begin
                        $display("%0t: hue expected %0d actual %0d",
                                 $time, want.hue, got.hue);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (got.saturation !== want.saturation) begin
                        $display("%0t: saturation expected %0d actual %0d",
                                 $time, want.saturation, got.saturation);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (got.brightness !== want.brightness) begin
                        $display("%0t: brightness expected %0d actual %0d",
                                 $time, want.brightness, got.brightness);
                        mismatch_count = mismatch_count + 1;
                    end
                end
                colours_checked = colours_checked + 1;
            end

            if (stall_left > 0) begin
                stall_left    = stall_left - 1;
                m_axis_tready <= 1'b0;
            end else if (!stall_done && colours_checked >= STALL_AT) begin
                stall_done    = 1'b1;
                stall_left    = STALL_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (colours_checked >= RECV_CALM_LO &&
                         colours_checked < RECV_CALM_HI) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

endmodule
